/* src/pmu_frame_second_aligner_defines.svh */
// Assertion macros shared by the frame second aligner RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef PMU_FRAME_SECOND_ALIGNER_DEFINES_SVH
`define PMU_FRAME_SECOND_ALIGNER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PFSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define PFSA_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define PFSA_ASSERT(label, prop, msg)
`define PFSA_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

/* src/pfsa_pkg.sv */
// Shared types and constants of the frame second aligner.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
package pfsa_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 256;
  localparam int unsigned LOCK_MODULUS_DEF = 10;

  localparam int unsigned LEN_W    = 16;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned TOT_W    = 16;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DROPPED     = 4'd0,
    ST_SYNC_WAIT   = 4'd1,
    ST_SYNC_START  = 4'd2,
    ST_SYNC_RECORD = 4'd3,
    ST_SYNC_ABORT  = 4'd4,
    ST_LOCKED      = 4'd5,
    ST_OK          = 4'd6,
    ST_MISMATCH    = 4'd7,
    ST_CLOSED      = 4'd8,
    ST_REALIGNED   = 4'd9,
    ST_LOST        = 4'd10
  } code_t;

  // State updates the datapath applies
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DROP,
    ACT_START,
    ACT_LOCK,
    ACT_ABORT,
    ACT_RECORD,
    ACT_SLOT_INC,
    ACT_CLOSE,
    ACT_JUMP,
    ACT_REALIGN,
    ACT_LOST
  } act_t;

  // Fraction store read address select
  typedef enum logic [1:0] {
    RD_SLOT,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    act_t    act;
    rd_sel_t rd_sel;
    logic    srch_inc;
    logic    load_out;
    code_t   code;
  } pfsa_cmd_t;

  typedef struct packed {
    logic len_ok;
    logic fill;
    logic begun;
    logic frac_zero;
    logic sec_eq_present;
    logic sec_eq_next;
    logic sec_gt_next;
    logic table_full;
    logic mod_zero;
    logic slot_oob;
    logic rd_match;
    logic srch_last;
    logic out_free;
  } pfsa_sts_t;

endpackage

/* src/pfsa_in_if.sv */
// Input channel carrying one frame header per beat.
// Depends on pfsa_pkg for field widths.
interface pfsa_in_if;
  import pfsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  frame_length;
  logic [SEC_W-1:0]  second_of_century;
  logic [FRAC_W-1:0] fraction_of_second;

  modport source (output valid, frame_length, second_of_century, fraction_of_second,
                  input ready);
  modport sink (input valid, frame_length, second_of_century, fraction_of_second,
                output ready);
endinterface

/* src/pfsa_out_if.sv */
// Result channel carrying one status beat per accepted frame.
// Depends on pfsa_pkg for field widths.
interface pfsa_out_if;
  import pfsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [SLOT_W-1:0]   learned_count;
  logic [SEC_W-1:0]    current_second;
  logic [TOT_W-1:0]    nonstandard_total;
  logic [TOT_W-1:0]    sync_abort_total;
  logic [TOT_W-1:0]    short_second_total;
  logic [TOT_W-1:0]    seconds_done_total;
  logic [TOT_W-1:0]    jump_total;
  logic [TOT_W-1:0]    lost_total;

  modport source (output valid, status, slot_index, learned_count, current_second,
                  nonstandard_total, sync_abort_total, short_second_total,
                  seconds_done_total, jump_total, lost_total,
                  input ready);
  modport sink (input valid, status, slot_index, learned_count, current_second,
                nonstandard_total, sync_abort_total, short_second_total,
                seconds_done_total, jump_total, lost_total,
                output ready);
endinterface

/* src/pfsa_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module pfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write when enabled, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/pfsa_ctrl.sv */
// Controller of the frame second aligner: sequences classify, check, search, finish.
// Depends on pfsa_pkg for command and status structs.
module pfsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfsa_pkg::pfsa_sts_t sts,
  output pfsa_pkg::pfsa_cmd_t cmd
);
  import pfsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CHECK,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  code_t  code_r, code_nxt;

  // Decide the next state, the update and the result code
  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd          = '0;
    cmd.act      = ACT_NONE;
    cmd.rd_sel   = RD_SLOT;
    cmd.code     = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        state_nxt = S_FINISH;
        if (!sts.len_ok) begin
          cmd.act  = ACT_DROP;
          code_nxt = ST_DROPPED;
        end else if (!sts.fill) begin
          if (!sts.begun) begin
            if (sts.frac_zero) begin
              cmd.act  = ACT_START;
              code_nxt = ST_SYNC_START;
            end else begin
              code_nxt = ST_SYNC_WAIT;
            end
          end else if (sts.sec_eq_next && sts.frac_zero) begin
            if (sts.mod_zero) begin
              cmd.act  = ACT_LOCK;
              code_nxt = ST_LOCKED;
            end else begin
              cmd.act  = ACT_ABORT;
              code_nxt = ST_SYNC_ABORT;
            end
          end else if (sts.sec_gt_next || sts.table_full) begin
            cmd.act  = ACT_ABORT;
            code_nxt = ST_SYNC_ABORT;
          end else begin
            cmd.act  = ACT_RECORD;
            code_nxt = ST_SYNC_RECORD;
          end
        end else if (sts.sec_eq_present && !sts.frac_zero) begin
          if (sts.slot_oob) begin
            cmd.act  = ACT_SLOT_INC;
            code_nxt = ST_MISMATCH;
          end else begin
            cmd.rd_sel = RD_SLOT;
            state_nxt  = S_CHECK;
          end
        end else if (sts.sec_eq_next && sts.frac_zero) begin
          cmd.act  = ACT_CLOSE;
          code_nxt = ST_CLOSED;
        end else begin
          cmd.act    = ACT_JUMP;
          cmd.rd_sel = RD_FIRST;
          state_nxt  = S_SEARCH;
        end
      end
      S_CHECK: begin
        cmd.act   = ACT_SLOT_INC;
        code_nxt  = sts.rd_match ? ST_OK : ST_MISMATCH;
        state_nxt = S_FINISH;
      end
      S_SEARCH: begin
        if (sts.rd_match) begin
          cmd.act   = ACT_REALIGN;
          code_nxt  = ST_REALIGNED;
          state_nxt = S_FINISH;
        end else if (sts.srch_last) begin
          cmd.act   = ACT_LOST;
          code_nxt  = ST_LOST;
          state_nxt = S_FINISH;
        end else begin
          cmd.srch_inc = 1'b1;
          cmd.rd_sel   = RD_NEXT;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // Hold state and result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_DROPPED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

/* src/pfsa_dp.sv */
// Datapath of the frame second aligner: header capture, sync and fill state,
// fraction store, wrapping counters and result register. Depends on pfsa_pkg, pfsa_ram.
module pfsa_dp #(
  parameter int unsigned MAX_SAMPLES  = pfsa_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned LOCK_MODULUS = pfsa_pkg::LOCK_MODULUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfsa_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic [pfsa_pkg::LEN_W-1:0]      in_frame_length,
  input  logic [pfsa_pkg::SEC_W-1:0]      in_second,
  input  logic [pfsa_pkg::FRAC_W-1:0]     in_fraction,
  input  pfsa_pkg::pfsa_cmd_t             cmd,
  output pfsa_pkg::pfsa_sts_t             sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [pfsa_pkg::STATUS_W-1:0]   out_status,
  output logic [pfsa_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [pfsa_pkg::SLOT_W-1:0]     out_learned_count,
  output logic [pfsa_pkg::SEC_W-1:0]      out_current_second,
  output logic [pfsa_pkg::TOT_W-1:0]      out_nonstandard_total,
  output logic [pfsa_pkg::TOT_W-1:0]      out_sync_abort_total,
  output logic [pfsa_pkg::TOT_W-1:0]      out_short_second_total,
  output logic [pfsa_pkg::TOT_W-1:0]      out_seconds_done_total,
  output logic [pfsa_pkg::TOT_W-1:0]      out_jump_total,
  output logic [pfsa_pkg::TOT_W-1:0]      out_lost_total
);
  import pfsa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned MOD_W   = $clog2(LOCK_MODULUS + 1);
  localparam int unsigned MOD_ONE = 1 % LOCK_MODULUS;

  logic [LEN_W-1:0]  exp_len_r;
  logic [LEN_W-1:0]  len_r;
  logic [SEC_W-1:0]  sec_r;
  logic [FRAC_W-1:0] frac_r;

  logic              fill_r, fill_nxt;
  logic              begun_r, begun_nxt;
  logic [SEC_W-1:0]  present_r, present_nxt;
  logic [CNT_W-1:0]  learned_r, learned_nxt;
  logic [MOD_W-1:0]  mod_r, mod_nxt;
  logic [CNT_W-1:0]  slot_r, slot_nxt;
  logic [IDX_W-1:0]  srch_r, srch_nxt;
  logic [TOT_W-1:0]  nonstd_r, nonstd_nxt;
  logic [TOT_W-1:0]  abort_r, abort_nxt;
  logic [TOT_W-1:0]  short_r, short_nxt;
  logic [TOT_W-1:0]  done_r, done_nxt;
  logic [TOT_W-1:0]  jump_r, jump_nxt;
  logic [TOT_W-1:0]  lost_r, lost_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [SLOT_W-1:0] out_learned_r;
  logic [SEC_W-1:0]  out_second_r;
  logic [TOT_W-1:0]  out_nonstd_r;
  logic [TOT_W-1:0]  out_abort_r;
  logic [TOT_W-1:0]  out_short_r;
  logic [TOT_W-1:0]  out_done_r;
  logic [TOT_W-1:0]  out_jump_r;
  logic [TOT_W-1:0]  out_lost_r;

  logic [SEC_W-1:0]  next_sec;
  logic [IDX_W-1:0]  srch_succ;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [FRAC_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [FRAC_W-1:0] ram_rdata;

  assign next_sec  = present_r + SEC_W'(1);
  assign srch_succ = srch_r + IDX_W'(1);

  // Report conditions to the controller
  always_comb begin
    sts                = '0;
    sts.len_ok         = (len_r == exp_len_r);
    sts.fill           = fill_r;
    sts.begun          = begun_r;
    sts.frac_zero      = (frac_r == '0);
    sts.sec_eq_present = (sec_r == present_r);
    sts.sec_eq_next    = (sec_r == next_sec);
    sts.sec_gt_next    = (sec_r > next_sec);
    sts.table_full     = (learned_r >= CNT_W'(MAX_SAMPLES));
    sts.mod_zero       = (mod_r == '0);
    sts.slot_oob       = (slot_r >= learned_r) || (slot_r >= CNT_W'(MAX_SAMPLES));
    sts.rd_match       = (ram_rdata == frac_r);
    sts.srch_last      = (CNT_W'(srch_r) + CNT_W'(1) >= learned_r) ||
                         (srch_r == IDX_W'(MAX_SAMPLES - 1));
    sts.out_free       = !out_valid_r || out_ready;
  end

  // Fraction store: write on sync start and record, read for check and search
  always_comb begin
    ram_we    = (cmd.act == ACT_START) || (cmd.act == ACT_RECORD);
    ram_waddr = (cmd.act == ACT_START) ? '0 : learned_r[IDX_W-1:0];
    ram_wdata = (cmd.act == ACT_START) ? '0 : frac_r;
    case (cmd.rd_sel)
      RD_SLOT:  ram_raddr = slot_r[IDX_W-1:0];
      RD_FIRST: ram_raddr = '0;
      RD_NEXT:  ram_raddr = srch_succ;
      default:  ram_raddr = '0;
    endcase
  end

  pfsa_ram #(
    .WIDTH (FRAC_W),
    .DEPTH (MAX_SAMPLES)
  ) u_frac_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Apply the commanded update
  always_comb begin
    fill_nxt    = fill_r;
    begun_nxt   = begun_r;
    present_nxt = present_r;
    learned_nxt = learned_r;
    mod_nxt     = mod_r;
    slot_nxt    = slot_r;
    srch_nxt    = cmd.srch_inc ? srch_succ : srch_r;
    nonstd_nxt  = nonstd_r;
    abort_nxt   = abort_r;
    short_nxt   = short_r;
    done_nxt    = done_r;
    jump_nxt    = jump_r;
    lost_nxt    = lost_r;
    case (cmd.act)
      ACT_DROP: begin
        nonstd_nxt = nonstd_r + TOT_W'(1);
      end
      ACT_START: begin
        begun_nxt   = 1'b1;
        present_nxt = sec_r;
        learned_nxt = CNT_W'(1);
        mod_nxt     = MOD_W'(MOD_ONE);
      end
      ACT_LOCK: begin
        fill_nxt    = 1'b1;
        slot_nxt    = CNT_W'(1);
        present_nxt = sec_r;
      end
      ACT_ABORT: begin
        begun_nxt   = 1'b0;
        learned_nxt = '0;
        mod_nxt     = '0;
        abort_nxt   = abort_r + TOT_W'(1);
      end
      ACT_RECORD: begin
        learned_nxt = learned_r + CNT_W'(1);
        mod_nxt     = (mod_r == MOD_W'(LOCK_MODULUS - 1)) ? '0 : mod_r + MOD_W'(1);
      end
      ACT_SLOT_INC: begin
        if (slot_r < CNT_W'(MAX_SAMPLES)) begin
          slot_nxt = slot_r + CNT_W'(1);
        end
      end
      ACT_CLOSE: begin
        if (slot_r != learned_r) begin
          short_nxt = short_r + TOT_W'(1);
        end
        done_nxt    = done_r + TOT_W'(1);
        slot_nxt    = CNT_W'(1);
        present_nxt = sec_r;
      end
      ACT_JUMP: begin
        jump_nxt    = jump_r + TOT_W'(1);
        present_nxt = sec_r;
        srch_nxt    = '0;
      end
      ACT_REALIGN: begin
        slot_nxt = CNT_W'(srch_r) + CNT_W'(1);
      end
      ACT_LOST: begin
        fill_nxt    = 1'b0;
        begun_nxt   = 1'b0;
        learned_nxt = '0;
        mod_nxt     = '0;
        lost_nxt    = lost_r + TOT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Free the result register when taken, refill it on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r   <= '0;
      fill_r      <= 1'b0;
      begun_r     <= 1'b0;
      present_r   <= '0;
      learned_r   <= '0;
      mod_r       <= '0;
      slot_r      <= '0;
      nonstd_r    <= '0;
      abort_r     <= '0;
      short_r     <= '0;
      done_r      <= '0;
      jump_r      <= '0;
      lost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        exp_len_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      begun_r     <= begun_nxt;
      present_r   <= present_nxt;
      learned_r   <= learned_nxt;
      mod_r       <= mod_nxt;
      slot_r      <= slot_nxt;
      nonstd_r    <= nonstd_nxt;
      abort_r     <= abort_nxt;
      short_r     <= short_nxt;
      done_r      <= done_nxt;
      jump_r      <= jump_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the header beat, advance the search index, load the result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len_r  <= in_frame_length;
      sec_r  <= in_second;
      frac_r <= in_fraction;
    end
    srch_r <= srch_nxt;
    if (cmd.load_out) begin
      out_status_r  <= cmd.code;
      out_slot_r    <= SLOT_W'(slot_r);
      out_learned_r <= SLOT_W'(learned_r);
      out_second_r  <= present_r;
      out_nonstd_r  <= nonstd_r;
      out_abort_r   <= abort_r;
      out_short_r   <= short_r;
      out_done_r    <= done_r;
      out_jump_r    <= jump_r;
      out_lost_r    <= lost_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_slot_index         = out_slot_r;
  assign out_learned_count      = out_learned_r;
  assign out_current_second     = out_second_r;
  assign out_nonstandard_total  = out_nonstd_r;
  assign out_sync_abort_total   = out_abort_r;
  assign out_short_second_total = out_short_r;
  assign out_seconds_done_total = out_done_r;
  assign out_jump_total         = out_jump_r;
  assign out_lost_total         = out_lost_r;

endmodule

/* src/pmu_frame_second_aligner.sv */
// Frame second aligner: classifies phasor frame headers against a learned
// per-second fraction pattern. Input beats on in_ch carry frame length, second
// and fraction word; each accepted beat yields exactly one result beat on
// out_ch with a status code, slot and learned counts, the current second and
// six wrapping event counters, all giving the state after that frame.
// cfg_we/cfg_wdata set the expected frame length; write it only while idle.
// A dropped, sync or second-close frame passes the classify and finish steps;
// an in-second frame within the learned slots adds a check step (one fraction
// store read), and an out-of-sequence frame adds a realignment search that
// reads one fraction store entry per cycle, up to learned_count entries. One
// frame is in work at a time; the next frame is accepted once the result is
// parked in the output register, and the input waits meanwhile. A stalled
// receiver holds the result register; a following frame is still accepted
// and processed, then waits in the finish step until the register frees.
// Synchronous reset clears mode, counts and the result valid; the fraction
// store is not cleared and needs no clearing pass.
module pmu_frame_second_aligner #(
  parameter int unsigned MAX_SAMPLES  = pfsa_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned LOCK_MODULUS = pfsa_pkg::LOCK_MODULUS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pfsa_pkg::LEN_W-1:0] cfg_wdata,
  pfsa_in_if.sink                    in_ch,
  pfsa_out_if.source                 out_ch
);
  import pfsa_pkg::*;
`include "pmu_frame_second_aligner_defines.svh"

  pfsa_cmd_t cmd;
  pfsa_sts_t sts;

  pfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfsa_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .LOCK_MODULUS (LOCK_MODULUS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_frame_length        (in_ch.frame_length),
    .in_second              (in_ch.second_of_century),
    .in_fraction            (in_ch.fraction_of_second),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_ready              (out_ch.ready),
    .out_valid              (out_ch.valid),
    .out_status             (out_ch.status),
    .out_slot_index         (out_ch.slot_index),
    .out_learned_count      (out_ch.learned_count),
    .out_current_second     (out_ch.current_second),
    .out_nonstandard_total  (out_ch.nonstandard_total),
    .out_sync_abort_total   (out_ch.sync_abort_total),
    .out_short_second_total (out_ch.short_second_total),
    .out_seconds_done_total (out_ch.seconds_done_total),
    .out_jump_total         (out_ch.jump_total),
    .out_lost_total         (out_ch.lost_total)
  );

  // No second frame is taken while one is in work
  `PFSA_ASSERT_NEXT(a_one_in_work, in_ch.valid && in_ch.ready, !in_ch.ready, "frame accepted while busy")
  // The result register is loaded only when free
  `PFSA_ASSERT(a_load_free, !cmd.load_out || sts.out_free, "result overwritten before taken")
  // A fraction is recorded only below the store depth
  `PFSA_ASSERT(a_record_room, (cmd.act != ACT_RECORD) || !sts.table_full, "record into full store")
  // A capture happens only on an accepted beat
  `PFSA_ASSERT(a_capture_accept, !cmd.capture || in_ch.ready, "capture outside idle")

endmodule
